// File: rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared widths, point type, pipeline tag and controller states.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // Store geometry and number formats.
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 32;
  localparam int T_W        = 17;
  localparam int FRAC_W     = 16;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W = IDX_W + 3 * COORD_W + T_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 3 * COORD_W;

  // A level does not end before its cycle counter reaches this value, so that
  // the next level never reads an entry before its write-back has landed.
  localparam logic [IDX_W-1:0] LVL_MIN_LAST = IDX_W'(4);

  // One control point or one working-row entry.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Bookkeeping that travels with a lerp through the datapath.
  typedef struct packed {
    logic             valid;
    logic             fin;
    logic [IDX_W-1:0] widx;
  } lerp_tag_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

endpackage

// File: rtl/bdc_lerp3.sv
// ----------------------------------------------------------------------------
// Three-lane lerp datapath
// Computes p0 + floor((p1 - p0) * t / 2^16) for x, y and z: the difference
// and the product are registered, and the sum is combinational off the product.
// ----------------------------------------------------------------------------
module bdc_lerp3
  import bdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [T_W-1:0]   t,
  input  lerp_tag_t        in_tag,
  input  point_t           p0,
  input  point_t           p1,
  output lerp_tag_t        out_tag,
  output point_t           out_pt
);

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + T_W + 1;

  logic signed [COORD_W-1:0] p0_c   [3];
  logic signed [COORD_W-1:0] p1_c   [3];
  logic signed [DIFF_W-1:0]  a_d    [3];
  logic signed [COORD_W-1:0] a_p0   [3];
  logic signed [PROD_W-1:0]  b_prod [3];
  logic signed [COORD_W-1:0] b_p0   [3];
  logic signed [COORD_W-1:0] sum_c  [3];
  logic signed [T_W:0]       t_s;
  lerp_tag_t                 a_tag;
  lerp_tag_t                 b_tag;

  // Split the points into lanes.
  assign p0_c[0] = p0.x;
  assign p0_c[1] = p0.y;
  assign p0_c[2] = p0.z;
  assign p1_c[0] = p1.x;
  assign p1_c[1] = p1.y;
  assign p1_c[2] = p1.z;
  assign t_s     = $signed({1'b0, t});

  // Tag pipeline; only the valid bits need a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid <= 1'b0;
      b_tag.valid <= 1'b0;
    end else begin
      a_tag.valid <= in_tag.valid;
      b_tag.valid <= a_tag.valid;
    end
    a_tag.fin  <= in_tag.fin;
    a_tag.widx <= in_tag.widx;
    b_tag.fin  <= a_tag.fin;
    b_tag.widx <= a_tag.widx;
  end

  // Per-lane difference, product and sum.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_ff @(posedge clk) begin
      a_d[k]    <= DIFF_W'(p1_c[k]) - DIFF_W'(p0_c[k]);
      a_p0[k]   <= p0_c[k];
      b_prod[k] <= PROD_W'(a_d[k]) * PROD_W'(t_s);
      b_p0[k]   <= a_p0[k];
    end
    // The exact result lies between p0 and p1, so the low word of the
    // shifted product is enough.
    assign sum_c[k] = b_p0[k] + b_prod[k][COORD_W+FRAC_W-1:FRAC_W];
  end

  assign out_tag  = b_tag;
  assign out_pt.x = sum_c[0];
  assign out_pt.y = sum_c[1];
  assign out_pt.z = sum_c[2];

endmodule

// File: rtl/bezier_de_casteljau_eval.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator, de Casteljau
// Holds up to 16 control points and evaluates the 3-D curve at a parameter t
// by repeated linear interpolation over a working row kept in memory.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: mode; tdata: index, x, y, z, t
// m_axis    out  m_axis_tvalid/tready   tdata: x, y, z of the curve point
// cfg       in   cfg_valid/cfg_ready    cfg_data: point_count
//
// A write beat is taken whenever the block is idle. An evaluate beat with n
// points in use (n below 2 counts as 2) runs levels L = 1..n-1, level L
// reading entries 0..n-L, then loads the output register; no beat is taken
// meanwhile. One memory read per cycle feeds a single three-lane lerp unit,
// and a floor on each level's length covers the write-back. Reset clears the
// controller and point_count goes to 4; the stores are undefined until
// written. A stalled output holds the result while the next beat is taken; a
// second result waits until the output register frees up.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval
  import bdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: point_index[4], in_x[32], in_y[32], in_z[32], param_t[17]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: out_x[32], out_y[32], out_z[32]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int X_LO = IDX_W;
  localparam int Y_LO = X_LO + COORD_W;
  localparam int Z_LO = Y_LO + COORD_W;
  localparam int T_LO = Z_LO + COORD_W;

  point_t ctl_mem  [MAX_POINTS];
  point_t work_mem [MAX_POINTS];

  state_t           state;
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] n2;
  logic             single;
  logic [T_W-1:0]   t_sat;
  logic [IDX_W-1:0] lvl;
  logic [IDX_W-1:0] cyc;
  logic [IDX_W-1:0] rlast;
  logic             lvl_fin;
  logic             lvl_end;
  logic             rd_go;
  logic [IDX_W-1:0] rd_addr;

  logic             s1_valid;
  logic             s1_first;
  logic             s1_ctl;
  logic             s1_fin;
  logic [IDX_W-1:0] s1_widx;
  point_t           ctl_q;
  point_t           work_q;
  point_t           rd_pt;
  point_t           prev;
  point_t           in_pt;
  point_t           w_pt;
  point_t           res;
  point_t           out_pt;
  logic             res_valid;
  lerp_tag_t        l_tag;
  lerp_tag_t        w_tag;

  logic             in_beat;
  logic             out_free;
  logic             out_load;
  logic [CNT_W-1:0] n_in;
  logic [T_W-1:0]   t_in;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  // Clamp point count and parameter for a new evaluation.
  always_comb begin
    if (point_count == '0) begin
      n_in = CNT_W'(1);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      n_in = CNT_W'(MAX_POINTS);
    end else begin
      n_in = point_count;
    end
    t_in = s_axis_tdata[T_LO +: T_W];
    if (t_in > T_ONE) begin
      t_in = T_ONE;
    end
  end

  assign in_pt.x = s_axis_tdata[X_LO +: COORD_W];
  assign in_pt.y = s_axis_tdata[Y_LO +: COORD_W];
  assign in_pt.z = s_axis_tdata[Z_LO +: COORD_W];

  // Level sequencing: level L reads entries 0 .. n-L of the row.
  assign rlast   = IDX_W'(n2 - CNT_W'(lvl));
  assign lvl_fin = (CNT_W'(lvl) == n2 - CNT_W'(1));
  assign lvl_end = (cyc >= rlast) && (cyc >= LVL_MIN_LAST);
  assign rd_go   = (state == ST_RUN) && (cyc <= rlast);
  // With a single point the curve is that point: lerp it with itself.
  assign rd_addr = single ? '0 : cyc;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_WAIT) && res_valid && out_free;

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lvl   <= '0;
      cyc   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat && s_axis_tuser) begin
            state <= ST_RUN;
            lvl   <= IDX_W'(1);
            cyc   <= '0;
          end
        end
        ST_RUN: begin
          if (lvl_end) begin
            cyc <= '0;
            if (lvl_fin) begin
              state <= ST_WAIT;
            end else begin
              lvl <= lvl + IDX_W'(1);
            end
          end else begin
            cyc <= cyc + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Evaluation settings captured with the beat.
  always_ff @(posedge clk) begin
    if (in_beat && s_axis_tuser) begin
      n2     <= (n_in < CNT_W'(2)) ? CNT_W'(2) : n_in;
      single <= (n_in == CNT_W'(1));
      t_sat  <= t_in;
    end
  end

  // Control point store: written by write beats, read in the first level.
  always_ff @(posedge clk) begin
    if (in_beat && !s_axis_tuser) begin
      ctl_mem[s_axis_tdata[IDX_W-1:0]] <= in_pt;
    end
    ctl_q <= ctl_mem[rd_addr];
  end

  // Working row: written back by the lerp unit, read in later levels.
  always_ff @(posedge clk) begin
    if (w_tag.valid) begin
      work_mem[w_tag.widx] <= w_pt;
    end
    work_q <= work_mem[rd_addr];
  end

  // Tag for the read that lands next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_go;
    end
    s1_first <= (cyc == '0);
    s1_ctl   <= (lvl == IDX_W'(1));
    s1_fin   <= lvl_fin;
    s1_widx  <= cyc - IDX_W'(1);
  end

  // Each read pairs with the previous one of the same level.
  assign rd_pt = s1_ctl ? ctl_q : work_q;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prev <= rd_pt;
    end
  end

  assign l_tag.valid = s1_valid && !s1_first;
  assign l_tag.fin   = s1_fin;
  assign l_tag.widx  = s1_widx;

  bdc_lerp3 u_lerp (
    .clk     (clk),
    .rst     (rst),
    .t       (t_sat),
    .in_tag  (l_tag),
    .p0      (prev),
    .p1      (rd_pt),
    .out_tag (w_tag),
    .out_pt  (w_pt)
  );

  // Final lerp of the last level is the curve point.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (w_tag.valid && w_tag.fin) begin
      res_valid <= 1'b1;
    end else if (out_load) begin
      res_valid <= 1'b0;
    end
    if (w_tag.valid && w_tag.fin) begin
      res <= w_pt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      out_pt <= res;
    end
  end

  assign m_axis_tdata = {out_pt.z, out_pt.y, out_pt.x};

  // A pending result only exists while an evaluation is open.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !res_valid)
    else $error("result pending while idle");

  // Write-backs come only from an evaluation in progress.
  assert property (@(posedge clk) disable iff (rst)
    w_tag.valid |-> (state != ST_IDLE))
    else $error("work row write outside an evaluation");

  // An evaluate beat starts the level sequencer.
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tuser) |=> (state == ST_RUN) && (lvl == IDX_W'(1)))
    else $error("evaluate beat did not start level one");

endmodule

// File: tb/bdc_tb_defs_pkg.sv
// ----------------------------------------------------------------------------
// Bezier evaluator testbench definitions
// Beat kinds carried on the input stream's tuser bit, shared by the stimulus
// and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package bdc_tb_defs_pkg;

  // Kind of an input beat.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

endpackage

// File: tb/bdc_stream_checker.sv
// ----------------------------------------------------------------------------
// Bezier evaluator stream checker
// Watches the configuration, input and output channels, keeps its own copy of
// the control points and point count, computes the expected curve point for
// every evaluate beat and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bdc_stream_checker
  import bdc_pkg::*;
  import bdc_tb_defs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata from bit 0: point_index[4], in_x[32], in_y[32], in_z[32], param_t[17]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: out_x[32], out_y[32], out_z[32]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  output int                    error_count,
  output int                    pending_count,
  output int                    checked_count
);

  localparam int REPORT_LIMIT = 10;

  // Shadow state: control points as wide integers and the point count.
  longint           ctrl_pts [MAX_POINTS][3];
  logic [CNT_W-1:0] active_count;
  point_t           curve_q [$];
  int               mismatches;
  int               checked;

  // One interpolation step; the arithmetic shift floors the scaled product.
  function automatic longint lerp_q16(longint p0, longint p1, longint t);
    return p0 + (((p1 - p0) * t) >>> FRAC_W);
  endfunction

  // Reduce the first active control points down to one curve point.
  function automatic point_t eval_curve(logic [T_W-1:0] t_raw);
    longint row [MAX_POINTS][3];
    longint t;
    int     n;
    point_t res;
    n = int'(active_count);
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
    for (int i = 0; i < n; i++)
      for (int k = 0; k < 3; k++)
        row[i][k] = ctrl_pts[i][k];
    for (int lvl = 1; lvl < n; lvl++)
      for (int i = 0; i + lvl < n; i++)
        for (int k = 0; k < 3; k++)
          row[i][k] = lerp_q16(row[i][k], row[i + 1][k], t);
    res.x = COORD_W'(row[0][0]);
    res.y = COORD_W'(row[0][1]);
    res.z = COORD_W'(row[0][2]);
    return res;
  endfunction

  // Monitor all three channels at the rising edge.
  always @(posedge clk) begin : monitor
    logic [IDX_W-1:0]   in_idx;
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [T_W-1:0]     in_t;
    point_t             want;
    point_t             got;
    if (rst) begin
      active_count = CNT_W'(4);
      curve_q.delete();
      mismatches = 0;
      checked    = 0;
      for (int i = 0; i < MAX_POINTS; i++)
        for (int k = 0; k < 3; k++)
          ctrl_pts[i][k] = 0;
    end else begin
      // Configuration beat.
      if (cfg_valid && cfg_ready)
        active_count = cfg_data;

      // Output beat against the oldest expected curve point.
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[COORD_W-1:0];
        got.y = m_axis_tdata[2*COORD_W-1:COORD_W];
        got.z = m_axis_tdata[3*COORD_W-1:2*COORD_W];
        if (curve_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        end else begin
          want = curve_q.pop_front();
          checked++;
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("[%0t] result %0d mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       $time, checked, want.x, want.y, want.z, got.x, got.y, got.z);
          end
        end
      end

      // Input beat: store a control point or queue a curve point.
      if (s_axis_tvalid && s_axis_tready) begin
        in_idx = s_axis_tdata[IDX_W-1:0];
        in_x   = s_axis_tdata[IDX_W +: COORD_W];
        in_y   = s_axis_tdata[IDX_W + COORD_W +: COORD_W];
        in_z   = s_axis_tdata[IDX_W + 2*COORD_W +: COORD_W];
        in_t   = s_axis_tdata[IDX_W + 3*COORD_W +: T_W];
        if (s_axis_tuser == MODE_WRITE) begin
          ctrl_pts[in_idx][0] = longint'($signed(in_x));
          ctrl_pts[in_idx][1] = longint'($signed(in_y));
          ctrl_pts[in_idx][2] = longint'($signed(in_z));
        end else begin
          curve_q = {curve_q, eval_curve(in_t)};
        end
      end
    end
    error_count   <= mismatches;
    pending_count <= curve_q.size();
    checked_count <= checked;
  end

endmodule

// File: tb/tb_bezier_de_casteljau_eval.sv
// ----------------------------------------------------------------------------
// Bezier evaluator testbench
// Writes control points and evaluates the curve under many point counts,
// with random gaps on the input and random stalls on the output; a separate
// checker predicts every curve point and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bezier_de_casteljau_eval;
  import bdc_pkg::*;
  import bdc_tb_defs_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 100;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = MODE_WRITE;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic [CNT_W-1:0]      cfg_data      = '0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_ready;

  int error_count;
  int pending_count;
  int checked_count;
  int beats_sent  = 0;
  int evals_sent  = 0;
  int count_sets  = 0;
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  int sink_hold   = 0;

  logic [CNT_W-1:0] phase_counts [8] = '{5'd16, 5'd2, 5'd3, 5'd0, 5'd8, 5'd31, 5'd1, 5'd12};

  // Clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bezier_de_casteljau_eval dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bdc_stream_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Output side: hold tready for a random number of cycles, mostly short.
  always @(negedge clk) begin : sink_ctrl
    int r;
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (!sink_stalls) begin
      m_axis_tready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_axis_tready = 1'b1;
        sink_hold     = $urandom_range(0, 3);
      end else if (r < 92) begin
        m_axis_tready = 1'b0;
        sink_hold     = $urandom_range(0, 2);
      end else begin
        m_axis_tready = 1'b0;
        sink_hold     = $urandom_range(8, 40);
      end
    end
  end

  // Coordinates: mostly full-range, some extremes and some small values.
  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return COORD_W'($urandom_range(0, 32'h0020_0000)) - COORD_W'(32'h0010_0000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Parameter: the ends, the range above one, and uniform values in between.
  function automatic logic [T_W-1:0] rand_param();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
      default: return T_W'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  // Present one input beat and hold it until it is taken.
  task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [T_W-1:0] t);
    int gap;
    int r;
    gap = 0;
    if (src_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 90)
        gap = $urandom_range(8, 40);
      else if (r >= 50)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = mode;
    s_axis_tdata  = IN_DATA_W'({t, z, y, x, idx});
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    beats_sent++;
    if (mode == MODE_EVAL)
      evals_sent++;
  endtask

  task automatic send_eval(input logic [T_W-1:0] t);
    send_beat(MODE_EVAL, '0, '0, '0, '0, t);
  endtask

  // Stop the input and let every outstanding result and write settle.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Change the point count while the block is idle.
  task automatic write_count(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    count_sets++;
  endtask

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [COORD_W-1:0] px, py, pz;
    logic [CNT_W-1:0]   count;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every slot so no evaluation reads an unwritten point; the first
    // four carry the coordinate extremes and are used by the reset count.
    for (int i = 0; i < MAX_POINTS; i++) begin
      case (i)
        0: begin px = 32'h7FFF_FFFF; py = 32'h8000_0000; pz = 32'h0000_0000; end
        1: begin px = 32'h8000_0000; py = 32'h7FFF_FFFF; pz = 32'hFFFF_FFFF; end
        2: begin px = 32'h7FFF_FFFF; py = 32'h7FFF_FFFF; pz = 32'h8000_0000; end
        3: begin px = 32'h8000_0000; py = 32'h0000_0000; pz = 32'h7FFF_FFFF; end
        default: begin px = rand_coord(); py = rand_coord(); pz = rand_coord(); end
      endcase
      send_beat(MODE_WRITE, IDX_W'(i), px, py, pz, T_W'($urandom));
    end

    // Parameter at zero, one, above one, half and the smallest step.
    send_eval('0);
    send_eval(T_ONE);
    send_eval({T_W{1'b1}});
    send_eval(T_ONE >> 1);
    send_eval(T_W'(1));

    // A single point, a count of zero, and a count above the store size.
    write_count(CNT_W'(1));
    send_eval(rand_param());
    write_count(CNT_W'(0));
    send_eval(rand_param());
    write_count({CNT_W{1'b1}});
    send_eval(T_ONE - 1);

    // Random phases, each under its own point count; every third phase runs
    // with no gaps and no stalls.
    for (int ph = 0; ph < PHASES; ph++) begin
      count = (ph < 8) ? phase_counts[ph] : CNT_W'($urandom_range(0, 31));
      write_count(count);
      src_gaps    = (ph % 3 != 2);
      sink_stalls = (ph % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 35)
          send_beat(MODE_WRITE, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                    rand_coord(), rand_coord(), rand_coord(), T_W'($urandom));
        else
          send_eval(rand_param());
      end
    end

    // Drain and let any stray result show up.
    s_axis_tvalid = 1'b0;
    sink_stalls   = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d evaluations) over %0d point-count settings.",
             beats_sent, evals_sent, count_sets);
    $display("Checked %0d curve points, %0d mismatches.", checked_count, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
